// ----- hdl/planar_uv_mapper_with_dedup_defines.svh -----
// ----------------------------------------------------------------------------
// Planar UV mapper assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PLANAR_UV_MAPPER_WITH_DEDUP_DEFINES_SVH
`define PLANAR_UV_MAPPER_WITH_DEDUP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PUVM_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("puvm port check failed");

// Next-cycle implication, held off during reset.
`define PUVM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("puvm port check failed");

`endif

// ----- hdl/puvm_pkg.sv -----
// ----------------------------------------------------------------------------
// Planar UV mapper package
// Sizes, register codes, shared types and state encodings.
// ----------------------------------------------------------------------------
package puvm_pkg;

	// Table capacity, a power of two from 16 upwards.
	localparam int TABLE_DEPTH = 1024;
	localparam int NUM_CELLS   = (TABLE_DEPTH >= 64) ? 32 : 8;
	localparam int ROWS        = TABLE_DEPTH / NUM_CELLS;
	localparam int CELL_W      = $clog2(NUM_CELLS);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int RCNT_W      = CNT_W - CELL_W;
	localparam int UV_INDEX_W  = 10;
	localparam int IDX_EXT_W   = (CNT_W > UV_INDEX_W) ? CNT_W : UV_INDEX_W;

	localparam int COORD_W = 32;
	localparam int TEX_W   = 16;
	localparam int KEY_W   = 2 * TEX_W;
	localparam int CFG_W   = 32;
	localparam int CFG_A_W = 3;

	// Divider geometry: quotient bits kept before saturation.
	localparam int Q_W    = 18;
	localparam int DIFF_W = COORD_W + 1;
	localparam int S95_W  = 23;
	localparam int MAG_W  = DIFF_W + S95_W;
	localparam int DEN_W  = 39;
	localparam int DSH_W  = DEN_W + Q_W;
	localparam int BASE_W = 17;
	localparam int SUM_W  = 20;
	localparam int CNTD_W = 5;

	// Reciprocal of five for a 13-bit operand, shift 18.
	localparam logic [15:0] RECIP5   = 16'd52429;
	localparam int          RECIP5_S = 18;

	typedef enum logic [CFG_A_W-1:0] {
		REG_U_MIN    = 3'd0,
		REG_U_MAX    = 3'd1,
		REG_V_MIN    = 3'd2,
		REG_V_MAX    = 3'd3,
		REG_U_ORIGIN = 3'd4,
		REG_U_SIZE   = 3'd5,
		REG_V_ORIGIN = 3'd6,
		REG_V_SIZE   = 3'd7
	} reg_idx_t;

	localparam logic [1:0] PLANE_XY  = 2'd0;
	localparam logic [1:0] PLANE_XZ  = 2'd1;
	localparam logic [1:0] PLANE_YZ  = 2'd2;
	localparam logic [1:0] PLANE_BAD = 2'd3;

	typedef enum logic [2:0] {
		A_IDLE, A_MUL, A_CHK, A_DIV, A_FIN
	} axis_state_t;

	typedef enum logic [1:0] {
		T_IDLE, T_MAP, T_SEARCH
	} top_state_t;

	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  row;
		logic [CELL_W-1:0] col;
		logic [KEY_W-1:0]  data;
	} wr_t;

	typedef struct packed {
		logic              found;
		logic [CELL_W-1:0] col;
	} chain_t;

endpackage

// ----- hdl/puvm_axis.sv -----
// ----------------------------------------------------------------------------
// Planar UV mapper axis unit
// Maps one coordinate onto the atlas region with a bit-serial floor divide.
// ----------------------------------------------------------------------------
module puvm_axis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [puvm_pkg::COORD_W-1:0] coord,
	input  logic signed [puvm_pkg::COORD_W-1:0] lo,
	input  logic signed [puvm_pkg::COORD_W-1:0] hi,
	input  logic        [puvm_pkg::TEX_W-1:0]   origin,
	input  logic        [puvm_pkg::TEX_W-1:0]   size,
	output logic                          done,
	output logic        [puvm_pkg::TEX_W-1:0]   tex
);
	import puvm_pkg::*;

	axis_state_t state_q, state_d;

	logic signed [DIFF_W-1:0] diff, span;
	logic [DIFF_W-1:0]  absd_q;
	logic [COORD_W-1:0] span_q;
	logic               span_ok_q, neg_q, ovf_q;
	logic [S95_W-1:0]   s95_q;
	logic [BASE_W-1:0]  base_q;
	logic [MAG_W-1:0]   mag_q;
	logic [DEN_W-1:0]   den_q;
	logic [MAG_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [Q_W-1:0]     quo_q;
	logic [CNTD_W-1:0]  cnt_q;
	logic [TEX_W-1:0]   tex_q;
	logic               done_q;
	logic [28:0]        s8_prod;
	logic [DEN_W-1:0]   den;
	logic               rem_ge;
	logic signed [SUM_W-1:0] qs, sum;

	assign diff = DIFF_W'(coord) - DIFF_W'(lo);
	assign span = DIFF_W'(hi) - DIFF_W'(lo);
	assign s8_prod = {3'b0, size[TEX_W-1:3]} * {13'b0, RECIP5};
	assign den = (DEN_W'(span_q) << 6) + (DEN_W'(span_q) << 5) + (DEN_W'(span_q) << 2);
	assign rem_ge = {1'b0, rem_q} >= dsh_q;

	assign qs = neg_q ? (-SUM_W'(quo_q) - SUM_W'(rem_q != '0)) : SUM_W'(quo_q);
	assign sum = SUM_W'(base_q) + qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == A_FIN);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: if (start) state_d = A_MUL;
			A_MUL:  state_d = span_ok_q ? A_CHK : A_FIN;
			A_CHK:  state_d = ({1'b0, mag_q} >= {den_q, Q_W'(0)}) ? A_FIN : A_DIV;
			A_DIV:  if (cnt_q == '0) state_d = A_FIN;
			A_FIN:  state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: if (start) begin
				absd_q    <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
				neg_q     <= diff[DIFF_W-1];
				span_ok_q <= !span[DIFF_W-1] && (span != '0);
				span_q    <= span[COORD_W-1:0];
				s95_q     <= (S95_W'(size) << 6) + (S95_W'(size) << 5) - S95_W'(size);
				base_q    <= BASE_W'(origin) + BASE_W'(s8_prod >> RECIP5_S);
				ovf_q     <= 1'b0;
				quo_q     <= '0;
				rem_q     <= '0;
			end
			A_MUL: begin
				mag_q <= MAG_W'(absd_q) * MAG_W'(s95_q);
				den_q <= den;
			end
			A_CHK: begin
				ovf_q <= {1'b0, mag_q} >= {den_q, Q_W'(0)};
				rem_q <= mag_q;
				dsh_q <= DSH_W'({den_q, (Q_W-1)'(0)});
				cnt_q <= CNTD_W'(Q_W - 1);
			end
			A_DIV: begin
				// one quotient bit a cycle, most significant first
				if (rem_ge) rem_q <= rem_q - MAG_W'(dsh_q);
				quo_q <= {quo_q[Q_W-2:0], rem_ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			A_FIN: begin
				if (ovf_q)                   tex_q <= neg_q ? '0 : '1;
				else if (sum[SUM_W-1])       tex_q <= '0;
				else if (sum > SUM_W'(16'hFFFF)) tex_q <= '1;
				else                         tex_q <= sum[TEX_W-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign tex  = tex_q;

endmodule

// ----- hdl/puvm_cell.sv -----
// ----------------------------------------------------------------------------
// Planar UV mapper table cell
// Holds one column of the pair table and extends the first-match chain.
// ----------------------------------------------------------------------------
module puvm_cell (
	input  logic                         clk,
	input  logic [puvm_pkg::CELL_W-1:0]  cell_id,
	input  logic [puvm_pkg::ROW_W-1:0]   rd_row,
	input  logic [puvm_pkg::KEY_W-1:0]   key,
	input  logic [puvm_pkg::CELL_W:0]    col_lim,
	input  puvm_pkg::wr_t                wr,
	input  puvm_pkg::chain_t             chain_in,
	output puvm_pkg::chain_t             chain_out
);
	import puvm_pkg::*;

	logic [KEY_W-1:0] mem [ROWS];
	logic [KEY_W-1:0] rd_q;
	logic             match;

	always_ff @(posedge clk) begin
		if (wr.en && wr.col == cell_id) mem[wr.row] <= wr.data;
		rd_q <= mem[rd_row];
	end

	// only entries below the fill count take part
	assign match = (rd_q == key) && ({1'b0, cell_id} < col_lim);

	assign chain_out.found = chain_in.found | match;
	assign chain_out.col   = chain_in.found ? chain_in.col : cell_id;

endmodule

// ----- hdl/planar_uv_mapper_with_dedup.sv -----
// ----------------------------------------------------------------------------
// Planar UV mapper with deduplicating pair table
// Projects a vertex onto an atlas region and returns a unique pair index.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one vertex item; busy stays high
// until the result item shows on the output ports for a single cycle with
// done high, and the receiver must take it then. An item passes through
// the accepting cycle, the two axis units, which run side by side with a
// one-bit-a-cycle floor divider each, until both report done, a register
// that collects both, a search row by row through the row of 32 cells over
// the rows that hold stored pairs (ending early on a hit), and the read
// register drain and result flag. The result shows in the cycle in which
// the next item may be taken. Configuration writes through
// cfg_we/cfg_index/cfg_data land at once and belong in idle time only. The
// table needs no clearing after reset: a fill count marks which entries
// count.
// ----------------------------------------------------------------------------
module planar_uv_mapper_with_dedup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [puvm_pkg::COORD_W-1:0] coord_x,
	input  logic signed [puvm_pkg::COORD_W-1:0] coord_y,
	input  logic signed [puvm_pkg::COORD_W-1:0] coord_z,
	input  logic        [1:0]                 plane,
	input  logic                              cfg_we,
	input  logic        [puvm_pkg::CFG_A_W-1:0] cfg_index,
	input  logic        [puvm_pkg::CFG_W-1:0]   cfg_data,
	output logic                              done,
	output logic        [puvm_pkg::UV_INDEX_W-1:0] uv_index,
	output logic        [puvm_pkg::TEX_W-1:0]   tex_u,
	output logic        [puvm_pkg::TEX_W-1:0]   tex_v,
	output logic                              was_new,
	output logic                              table_full
);
	import puvm_pkg::*;

	// configuration registers
	logic signed [COORD_W-1:0] u_min_q, u_max_q, v_min_q, v_max_q;
	logic [TEX_W-1:0] u_org_q, u_size_q, v_org_q, v_size_q;

	top_state_t state_q, state_d;

	logic accept;
	logic signed [COORD_W-1:0] cu, cv;
	logic u_done, v_done, u_done_q, v_done_q;
	logic [TEX_W-1:0] u_tex, v_tex;
	logic [1:0] plane_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;

	// search control
	logic [RCNT_W-1:0] row_q, row_s1, cnt_row, rows_used;
	logic [CELL_W-1:0] cnt_col;
	logic [CELL_W:0]   col_lim, col_lim_s1;
	logic              s1_vld, issue, hit_now, miss_now, full_now;
	chain_t            chain [NUM_CELLS+1];
	wr_t               wr;

	// result registers
	logic                 done_q, was_new_q, full_q;
	logic [CNT_W-1:0]     idx_q;
	logic [IDX_EXT_W-1:0] idx_ext;

	assign accept = start && (state_q == T_IDLE);
	assign busy   = (state_q != T_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_min_q  <= '0;
			u_max_q  <= COORD_W'(32'h0001_0000);
			v_min_q  <= '0;
			v_max_q  <= COORD_W'(32'h0001_0000);
			u_org_q  <= '0;
			u_size_q <= '1;
			v_org_q  <= '0;
			v_size_q <= '1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_U_MIN:    u_min_q  <= cfg_data;
				REG_U_MAX:    u_max_q  <= cfg_data;
				REG_V_MIN:    v_min_q  <= cfg_data;
				REG_V_MAX:    v_max_q  <= cfg_data;
				REG_U_ORIGIN: u_org_q  <= cfg_data[TEX_W-1:0];
				REG_U_SIZE:   u_size_q <= cfg_data[TEX_W-1:0];
				REG_V_ORIGIN: v_org_q  <= cfg_data[TEX_W-1:0];
				REG_V_SIZE:   v_size_q <= cfg_data[TEX_W-1:0];
				default: ;
			endcase
		end
	end

	// plane picks the source axis for each texture coordinate
	assign cu = (plane == PLANE_YZ) ? coord_y : coord_x;
	assign cv = (plane == PLANE_XY) ? coord_y : coord_z;

	puvm_axis u_axis_u (
		.clk(clk), .arst_n(arst_n), .start(accept), .coord(cu),
		.lo(u_min_q), .hi(u_max_q), .origin(u_org_q), .size(u_size_q),
		.done(u_done), .tex(u_tex)
	);

	puvm_axis u_axis_v (
		.clk(clk), .arst_n(arst_n), .start(accept), .coord(cv),
		.lo(v_min_q), .hi(v_max_q), .origin(v_org_q), .size(v_size_q),
		.done(v_done), .tex(v_tex)
	);

	// fill count split into full rows and the part row
	assign cnt_row   = count_q[CNT_W-1:CELL_W];
	assign cnt_col   = count_q[CELL_W-1:0];
	assign rows_used = cnt_row + RCNT_W'(cnt_col != '0);

	always_comb begin
		if (row_q < cnt_row)       col_lim = (CELL_W+1)'(NUM_CELLS);
		else if (row_q == cnt_row) col_lim = {1'b0, cnt_col};
		else                       col_lim = '0;
	end

	assign hit_now  = (state_q == T_SEARCH) && s1_vld && chain[NUM_CELLS].found;
	assign issue    = (state_q == T_SEARCH) && (row_q < rows_used) && !hit_now;
	assign miss_now = (state_q == T_SEARCH) && !s1_vld && (row_q >= rows_used);
	assign full_now = (count_q == CNT_W'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE:   if (accept) state_d = T_MAP;
			T_MAP:    if (u_done_q && v_done_q) state_d = T_SEARCH;
			T_SEARCH: if (hit_now || miss_now) state_d = T_IDLE;
			default:  state_d = T_IDLE;
		endcase
	end

	// control registers: axis completion, search pipe, fill count, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_done_q <= 1'b0;
			v_done_q <= 1'b0;
			s1_vld   <= 1'b0;
			row_q    <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			if (accept) begin
				u_done_q <= 1'b0;
				v_done_q <= 1'b0;
				row_q    <= '0;
			end else begin
				if (u_done) u_done_q <= 1'b1;
				if (v_done) v_done_q <= 1'b1;
				if (issue)  row_q    <= row_q + 1'b1;
			end
			s1_vld <= issue;
			if (miss_now && !full_now) count_q <= count_q + 1'b1;
			done_q <= hit_now || miss_now;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) plane_q <= plane;
		// invalid plane looks up the pair (0,0)
		if (state_q == T_MAP && u_done_q && v_done_q)
			key_q <= (plane_q == PLANE_BAD) ? '0 : {u_tex, v_tex};
		row_s1     <= row_q;
		col_lim_s1 <= col_lim;
		if (hit_now) begin
			idx_q     <= {row_s1, chain[NUM_CELLS].col};
			was_new_q <= 1'b0;
			full_q    <= 1'b0;
		end else if (miss_now) begin
			idx_q     <= full_now ? '0 : count_q;
			was_new_q <= !full_now;
			full_q    <= full_now;
		end
	end

	// append on a miss while room remains
	assign wr.en   = miss_now && !full_now;
	assign wr.row  = ROW_W'(cnt_row);
	assign wr.col  = cnt_col;
	assign wr.data = key_q;

	assign chain[0] = '{found: 1'b0, col: '0};

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		puvm_cell u_cell (
			.clk(clk),
			.cell_id(CELL_W'(g)),
			.rd_row(row_q[ROW_W-1:0]),
			.key(key_q),
			.col_lim(col_lim_s1),
			.wr(wr),
			.chain_in(chain[g]),
			.chain_out(chain[g+1])
		);
	end

	assign idx_ext    = IDX_EXT_W'(idx_q);
	assign done       = done_q;
	assign uv_index   = idx_ext[UV_INDEX_W-1:0];
	assign tex_u      = key_q[KEY_W-1:TEX_W];
	assign tex_v      = key_q[TEX_W-1:0];
	assign was_new    = was_new_q;
	assign table_full = full_q;

endmodule

// ----- hdl/puvm_chk.sv -----
// ----------------------------------------------------------------------------
// Planar UV mapper port checker
// Watches the handshake and result flags seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "planar_uv_mapper_with_dedup_defines.svh"

module puvm_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [puvm_pkg::UV_INDEX_W-1:0]   uv_index,
	input logic                              was_new,
	input logic                              table_full
);
	`PUVM_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`PUVM_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`PUVM_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`PUVM_ASSERT_NOW(a_flags_excl, clk, arst_n, done, !(was_new && table_full))
	`PUVM_ASSERT_NOW(a_full_index, clk, arst_n, done && table_full, uv_index == '0)
endmodule

bind planar_uv_mapper_with_dedup puvm_chk u_puvm_chk (.*);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Planar UV mapper with deduplicating pair table: testbench
// Drives vertex items through the command port and predicts each result with
// a local model of the projection and the pair table. Each result is checked
// field by field against the oldest prediction. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import puvm_pkg::*;

	// Fields of one vertex item.
	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [1:0]                pl;
	} vertex_t;

	// Fields of one result item.
	typedef struct {
		logic [UV_INDEX_W-1:0] idx;
		logic [TEX_W-1:0]      u;
		logic [TEX_W-1:0]      v;
		logic                  added;
		logic                  full;
	} uv_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [1:0] plane;
	logic cfg_we;
	logic [CFG_A_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic done;
	logic [UV_INDEX_W-1:0] uv_index;
	logic [TEX_W-1:0] tex_u;
	logic [TEX_W-1:0] tex_v;
	logic was_new;
	logic table_full;

	// Local copy of the register file.
	longint      bound_lo_u, bound_hi_u, bound_lo_v, bound_hi_v;
	int unsigned org_u, size_u, org_v, size_v;

	// Local copy of the pair table.
	logic [KEY_W-1:0] pair_store [TABLE_DEPTH];
	int unsigned      pair_count;

	uv_result_t pending_uv[$];
	vertex_t    recent_vertices[$];
	int         mismatches;

	planar_uv_mapper_with_dedup dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .plane(plane),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .uv_index(uv_index), .tex_u(tex_u), .tex_v(tex_v),
		.was_new(was_new), .table_full(table_full)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Map one coordinate onto the region: origin, a 2.5% margin and a 95% span,
	// the ratio rounded towards minus infinity, the sum saturated to 16 bits.
	function automatic logic [TEX_W-1:0] project_axis(longint c, longint lo, longint hi,
			int unsigned org, int unsigned sz);
		longint span;
		longint total;
		longint num;
		longint den;
		longint q;
		span  = hi - lo;
		total = longint'(org) + longint'(sz / 40);
		if (span > 0) begin
			num = longint'(sz) * 95 * (c - lo);
			den = span * 100;
			q   = num / den;
			if ((num % den) != 0 && num < 0)
				q = q - 1;
			total = total + q;
		end
		if (total < 0)
			return '0;
		if (total > 65535)
			return 16'hFFFF;
		return total[TEX_W-1:0];
	endfunction

	// Project a vertex and look its pair up, appending on a miss.
	function automatic uv_result_t map_and_dedup(vertex_t vx);
		uv_result_t r;
		logic [KEY_W-1:0] pair;
		bit hit;
		longint cu;
		longint cv;
		r = '{idx: '0, u: '0, v: '0, added: 1'b0, full: 1'b0};
		hit = 1'b0;
		if (vx.pl != PLANE_BAD) begin
			cu = (vx.pl == PLANE_YZ) ? longint'(vx.y) : longint'(vx.x);
			cv = (vx.pl == PLANE_XY) ? longint'(vx.y) : longint'(vx.z);
			r.u = project_axis(cu, bound_lo_u, bound_hi_u, org_u, size_u);
			r.v = project_axis(cv, bound_lo_v, bound_hi_v, org_v, size_v);
		end
		pair = {r.u, r.v};
		for (int i = 0; i < pair_count; i++) begin
			if (!hit && pair_store[i] == pair) begin
				hit = 1'b1;
				r.idx = i[UV_INDEX_W-1:0];
			end
		end
		if (!hit) begin
			if (pair_count < TABLE_DEPTH) begin
				r.idx = pair_count[UV_INDEX_W-1:0];
				pair_store[pair_count] = pair;
				pair_count++;
				r.added = 1'b1;
			end else begin
				r.full = 1'b1;
			end
		end
		return r;
	endfunction

	// Write one register and mirror it locally; call only while idle.
	task automatic write_reg(reg_idx_t r, logic [CFG_W-1:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_U_MIN:    bound_lo_u = longint'(signed'(d));
			REG_U_MAX:    bound_hi_u = longint'(signed'(d));
			REG_V_MIN:    bound_lo_v = longint'(signed'(d));
			REG_V_MAX:    bound_hi_v = longint'(signed'(d));
			REG_U_ORIGIN: org_u = 32'(d[TEX_W-1:0]);
			REG_U_SIZE:   size_u = 32'(d[TEX_W-1:0]);
			REG_V_ORIGIN: org_v = 32'(d[TEX_W-1:0]);
			REG_V_SIZE:   size_v = 32'(d[TEX_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic set_region(logic [CFG_W-1:0] umin, logic [CFG_W-1:0] umax,
			logic [CFG_W-1:0] vmin, logic [CFG_W-1:0] vmax,
			logic [CFG_W-1:0] uo, logic [CFG_W-1:0] us,
			logic [CFG_W-1:0] vo, logic [CFG_W-1:0] vs);
		write_reg(REG_U_MIN, umin);
		write_reg(REG_U_MAX, umax);
		write_reg(REG_V_MIN, vmin);
		write_reg(REG_V_MAX, vmax);
		write_reg(REG_U_ORIGIN, uo);
		write_reg(REG_U_SIZE, us);
		write_reg(REG_V_ORIGIN, vo);
		write_reg(REG_V_SIZE, vs);
	endtask

	// Hold until every result is back, then let the block settle.
	task automatic drain;
		while (pending_uv.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Hand in one vertex item after a random gap, and record its prediction.
	task automatic send_vertex(vertex_t vx);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40));
		repeat (gap) @(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		start   <= 1'b1;
		coord_x <= vx.x;
		coord_y <= vx.y;
		coord_z <= vx.z;
		plane   <= vx.pl;
		@(posedge clk);
		// busy was low, so the item is taken at this edge
		start <= 1'b0;
		pending_uv.push_back(map_and_dedup(vx));
		recent_vertices.push_back(vx);
		if (recent_vertices.size() > 64)
			void'(recent_vertices.pop_front());
		@(negedge clk);
	endtask

	function automatic vertex_t make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [1:0] pl);
		vertex_t vx;
		vx.x  = x;
		vx.y  = y;
		vx.z  = z;
		vx.pl = pl;
		return vx;
	endfunction

	// Pick a coordinate: mostly within the given bounds, sometimes anywhere or at an extreme.
	function automatic logic [31:0] pick_coord(longint lo, longint hi);
		longint span;
		span = hi - lo;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: begin
				if (span > 0)
					return 32'(lo + (longint'($urandom) % (span + 1)));
				return $urandom;
			end
		endcase
	endfunction

	// Random vertex, or a repeat of a recent one so that lookups hit.
	function automatic vertex_t pick_vertex;
		vertex_t vx;
		if (recent_vertices.size() != 0 && $urandom_range(0, 9) < 3)
			return recent_vertices[$urandom_range(0, recent_vertices.size() - 1)];
		vx.x  = pick_coord(bound_lo_u, bound_hi_u);
		vx.y  = ($urandom_range(0, 1) != 0) ? pick_coord(bound_lo_v, bound_hi_v)
			: pick_coord(bound_lo_u, bound_hi_u);
		vx.z  = pick_coord(bound_lo_v, bound_hi_v);
		vx.pl = ($urandom_range(0, 15) == 0) ? PLANE_BAD : 2'($urandom_range(0, 2));
		return vx;
	endfunction

	// Compare each result strobe with the oldest prediction.
	always @(posedge clk) begin
		uv_result_t want;
		if (arst_n && done) begin
			if (pending_uv.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: index %0d u %h v %h new %b full %b",
						uv_index, tex_u, tex_v, was_new, table_full);
			end else begin
				want = pending_uv.pop_front();
				if (uv_index !== want.idx || tex_u !== want.u || tex_v !== want.v ||
						was_new !== want.added || table_full !== want.full) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected index %0d u %h v %h",
							" new %b full %b, got index %0d u %h v %h new %b full %b"},
							want.idx, want.u, want.v, want.added, want.full,
							uv_index, tex_u, tex_v, was_new, table_full);
				end
			end
		end
	end

	// Every plane, coordinate extremes, invalid plane, repeats and out-of-bounds.
	task automatic test_planes_and_extremes;
		send_vertex(make_vertex(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, PLANE_XY));
		send_vertex(make_vertex(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, PLANE_XZ));
		send_vertex(make_vertex(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, PLANE_YZ));
		send_vertex(make_vertex(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, PLANE_BAD));
		// repeats of the same pair must hit
		send_vertex(make_vertex(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, PLANE_XY));
		send_vertex(make_vertex(32'h1234_5678, 32'h0, 32'h0, PLANE_BAD));
		send_vertex(make_vertex(32'h0, 32'h0, 32'h0, PLANE_XY));
		send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, PLANE_XZ));
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, PLANE_XY));
		send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, PLANE_YZ));
		send_vertex(make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PLANE_XZ));
		send_vertex(make_vertex(32'h0000_0001, 32'hFFFF_0000, 32'h0002_0000, PLANE_XY));
		drain();
	endtask

	// Zero and negative spans leave only the origin and margin.
	task automatic test_degenerate_span;
		set_region(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
			32'd1000, 32'd40000, 32'd65535, 32'd65535);
		send_vertex(make_vertex(32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, PLANE_XY));
		send_vertex(make_vertex(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, PLANE_XZ));
		send_vertex(make_vertex(32'h0, 32'h0003_0000, 32'h0, PLANE_YZ));
		drain();
	endtask

	// Widest bounds, spans of one, and the corners of origin and size.
	task automatic test_wide_bounds;
		set_region(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd0, 32'd0, 32'd65535, 32'd0);
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, PLANE_XY));
		drain();
		set_region(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd65535, 32'd65535, 32'd0, 32'd65535);
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, PLANE_XY));
		send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, PLANE_XZ));
		send_vertex(make_vertex(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, PLANE_YZ));
		drain();
		set_region(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h8000_0001,
			32'd30000, 32'd65535, 32'd20000, 32'd1);
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, PLANE_XZ));
		send_vertex(make_vertex(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, PLANE_YZ));
		drain();
	endtask

	// Random vertices under several random settings; the table fills on the way.
	task automatic test_random_vertices(int phases, int per_phase);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		for (int p = 0; p < phases; p++) begin
			a = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2 ** 20)) - 32'h8_0000;
			b = ($urandom_range(0, 5) == 0) ? $urandom : a + $urandom_range(1, 2 ** 22);
			c = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2 ** 20)) - 32'h8_0000;
			d = ($urandom_range(0, 5) == 0) ? $urandom : c + $urandom_range(1, 2 ** 22);
			set_region(a, b, c, d, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
			for (int i = 0; i < per_phase; i++)
				send_vertex(pick_vertex());
			drain();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		coord_x    = '0;
		coord_y    = '0;
		coord_z    = '0;
		plane      = PLANE_XY;
		cfg_we     = 1'b0;
		cfg_index  = REG_U_MIN;
		cfg_data   = '0;
		mismatches = 0;
		pair_count = 0;
		bound_lo_u = 0;
		bound_hi_u = 65536;
		bound_lo_v = 0;
		bound_hi_v = 65536;
		org_u      = 0;
		size_u     = 65535;
		org_v      = 0;
		size_v     = 65535;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_planes_and_extremes();
		test_degenerate_span();
		test_wide_bounds();
		test_random_vertices(10, 200);

		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#20ms;
		$display("testbench failed");
		$finish;
	end

endmodule
